FILE: rtl/su3sc_pkg.sv
// Package for the SU(3) structure-constant contraction block.
// Holds the datapath widths, micro-op types, the Lie recipe table and the coefficient table.
// No dependencies.
package su3sc_pkg;

    localparam int LW          = 34;   // Lie component part width
    localparam int MW          = 35;   // multiplier operand width
    localparam int PW          = 2 * MW;
    localparam int AW          = 100;  // product accumulator width
    localparam int TW          = 72;   // contraction total width
    localparam int STORE_DEPTH = 27;
    localparam int LIE_DEPTH   = 24;
    localparam int D_ENTRIES   = 58;
    localparam int F_ENTRIES   = 54;
    localparam int N_ENTRIES   = D_ENTRIES + F_ENTRIES;

    localparam logic [1:0] MODE_D    = 2'd0;
    localparam logic [1:0] MODE_F    = 2'd1;
    localparam logic [1:0] MODE_BOTH = 2'd2;

    localparam logic [30:0] Q_SQRT3 = 31'd1859775393;

    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;

    typedef struct packed {
        acc_op_t op;
        logic    shift32;
    } mac_ctrl_t;

    typedef struct packed {
        logic [63:0] r0;
        logic [63:0] r16;
        logic [63:0] r30;
        logic        ovf0;
        logic        ovf16;
        logic        ovf30;
    } mac_res_t;

    typedef enum logic [1:0] {LK_ADD, LK_SUB, LK_ISUB, LK_SQRT} lie_kind_t;

    typedef struct packed {
        logic [3:0] u;
        logic [3:0] v;
        lie_kind_t  kind;
    } lie_recipe_t;

    function automatic lie_recipe_t lie_recipe(input logic [2:0] k);
        lie_recipe_t r;
        case (k)
            3'd0:    r = '{u: 4'd1, v: 4'd3, kind: LK_ADD};
            3'd1:    r = '{u: 4'd1, v: 4'd3, kind: LK_ISUB};
            3'd2:    r = '{u: 4'd0, v: 4'd4, kind: LK_SUB};
            3'd3:    r = '{u: 4'd2, v: 4'd6, kind: LK_ADD};
            3'd4:    r = '{u: 4'd2, v: 4'd6, kind: LK_ISUB};
            3'd5:    r = '{u: 4'd5, v: 4'd7, kind: LK_ADD};
            3'd6:    r = '{u: 4'd5, v: 4'd7, kind: LK_ISUB};
            default: r = '{u: 4'd8, v: 4'd8, kind: LK_SQRT};
        endcase
        return r;
    endfunction

    // Magnitude codes in Q1.30
    function automatic logic [30:0] mag_of(input logic [2:0] code);
        logic [30:0] m;
        case (code)
            3'd0:    m = 31'd1073741824;
            3'd1:    m = 31'd536870912;
            3'd2:    m = 31'd929887697;
            3'd3:    m = 31'd619925131;
            3'd4:    m = 31'd309962566;
            default: m = 31'd0;
        endcase
        return m;
    endfunction

    function automatic logic [12:0] en(input int p, input int q, input int r,
                                       input int m, input int s);
        return 13'(p | (q << 3) | (r << 6) | (m << 9) | (s << 12));
    endfunction

    // Fields: [2:0] p, [5:3] q, [8:6] r, [11:9] magnitude code, [12] sign
    localparam logic [12:0] COEF_ROM [N_ENTRIES] = '{
        en(0,0,7,3,0), en(0,3,5,1,0), en(0,4,6,1,0), en(0,5,3,1,0), en(0,6,4,1,0),
        en(0,7,0,3,0), en(1,1,7,3,0), en(1,3,6,1,1), en(1,4,5,1,0), en(1,5,4,1,0),
        en(1,6,3,1,1), en(1,7,1,3,0), en(2,2,7,3,0), en(2,3,3,1,0), en(2,4,4,1,0),
        en(2,5,5,1,1), en(2,6,6,1,1), en(2,7,2,3,0), en(3,0,5,1,0), en(3,1,6,1,1),
        en(3,2,3,1,0), en(3,3,2,1,0), en(3,3,7,4,1), en(3,5,0,1,0), en(3,6,1,1,1),
        en(3,7,3,4,1), en(4,0,6,1,0), en(4,1,5,1,0), en(4,2,4,1,0), en(4,4,2,1,0),
        en(4,4,7,4,1), en(4,5,1,1,0), en(4,6,0,1,0), en(4,7,4,4,1), en(5,0,3,1,0),
        en(5,1,4,1,0), en(5,2,5,1,1), en(5,3,0,1,0), en(5,4,1,1,0), en(5,5,2,1,1),
        en(5,5,7,4,1), en(5,7,5,4,1), en(6,0,4,1,0), en(6,1,3,1,1), en(6,2,6,1,1),
        en(6,3,1,1,1), en(6,4,0,1,0), en(6,6,2,1,1), en(6,6,7,4,1), en(6,7,6,4,1),
        en(7,0,0,3,0), en(7,1,1,3,0), en(7,2,2,3,0), en(7,3,3,4,1), en(7,4,4,4,1),
        en(7,5,5,4,1), en(7,6,6,4,1), en(7,7,7,3,1),
        en(0,1,2,0,0), en(0,2,1,0,1), en(0,3,6,1,0), en(0,4,5,1,1), en(0,5,4,1,0),
        en(0,6,3,1,1), en(1,0,2,0,1), en(1,2,0,0,0), en(1,3,5,1,0), en(1,4,6,1,0),
        en(1,5,3,1,1), en(1,6,4,1,1), en(2,0,1,0,0), en(2,1,0,0,1), en(2,3,4,1,0),
        en(2,4,3,1,1), en(2,5,6,1,1), en(2,6,5,1,0), en(3,0,6,1,1), en(3,1,5,1,1),
        en(3,2,4,1,1), en(3,4,2,1,0), en(3,4,7,2,0), en(3,5,1,1,0), en(3,6,0,1,0),
        en(3,7,4,2,1), en(4,0,5,1,0), en(4,1,6,1,1), en(4,2,3,1,0), en(4,3,2,1,1),
        en(4,3,7,2,1), en(4,5,0,1,1), en(4,6,1,1,0), en(4,7,3,2,0), en(5,0,4,1,1),
        en(5,1,3,1,0), en(5,2,6,1,0), en(5,3,1,1,1), en(5,4,0,1,0), en(5,6,2,1,1),
        en(5,6,7,2,0), en(5,7,6,2,1), en(6,0,3,1,0), en(6,1,4,1,0), en(6,2,5,1,1),
        en(6,3,0,1,1), en(6,4,1,1,1), en(6,5,2,1,0), en(6,5,7,2,1), en(6,7,5,2,0),
        en(7,3,4,2,0), en(7,4,3,2,1), en(7,5,6,2,0), en(7,6,5,2,1)
    };

endpackage

FILE: rtl/su3sc_ram.sv
// Single-port-write, single-port-read synchronous memory, read data registered.
// Used for the element store and the Lie component store. No dependencies.
module su3sc_ram
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = 27
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/su3sc_mac.sv
// Shared multiplier with registered product, wide accumulator and three rounders.
// Depends on su3sc_pkg.
module su3sc_mac
(
    input  logic                    clk,
    input  logic signed [34:0]      op_a,
    input  logic signed [34:0]      op_b,
    input  su3sc_pkg::mac_ctrl_t    ctrl,
    output su3sc_pkg::mac_res_t     res
);
    import su3sc_pkg::*;

    localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    logic signed [PW-1:0] prod_reg;
    logic [AW-1:0]        acc_reg;
    logic [AW-1:0]        acc_next;
    logic [AW-1:0]        prod_ext;
    logic [AW-1:0]        addend;
    logic [AW-1:0]        v16;
    logic [AW-1:0]        v30;
    logic [AW-17:0]       s16;
    logic [AW-31:0]       s30;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        acc_reg  <= acc_next;
    end

    always_comb
    begin
        prod_ext = {{(AW-PW){prod_reg[PW-1]}}, prod_reg};
        addend   = ctrl.shift32 ? {prod_ext[AW-33:0], 32'b0} : prod_ext;
        case (ctrl.op)
            ACC_LOAD: acc_next = addend;
            ACC_ADD:  acc_next = acc_reg + addend;
            ACC_SUB:  acc_next = acc_reg - addend;
            default:  acc_next = acc_reg;
        endcase
    end

    // round half up, then clip to 64 bits
    always_comb
    begin
        v16 = acc_reg + AW'(32768);
        v30 = acc_reg + AW'(536870912);
        s16 = v16[AW-1:16];
        s30 = v30[AW-1:30];

        res.ovf0  = !((&acc_reg[AW-1:63]) || !(|acc_reg[AW-1:63]));
        res.ovf16 = !((&s16[AW-17:63]) || !(|s16[AW-17:63]));
        res.ovf30 = !((&s30[AW-31:63]) || !(|s30[AW-31:63]));
        res.r0    = res.ovf0 ? (acc_reg[AW-1] ? S64_MIN : S64_MAX) : acc_reg[63:0];
        res.r16   = res.ovf16 ? (s16[AW-17] ? S64_MIN : S64_MAX) : s16[63:0];
        res.r30   = res.ovf30 ? (s30[AW-31] ? S64_MIN : S64_MAX) : s30[63:0];
    end
endmodule

FILE: rtl/su3_structure_constant_contraction.sv
// Top level of the SU(3) structure-constant contraction block.
// Depends on su3sc_pkg, su3sc_ram and su3sc_mac.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+---------------------------------------------
//  s_      | in  | s_tvalid / s_tready   | tdata: element_index, element_real,
//          |     |                       |   element_imag; tuser: matrix_select;
//          |     |                       |   tlast: last_element
//  m_      | out | m_tvalid / m_tready   | tdata: result_real, result_imag;
//          |     |                       |   tuser: saturated
//  cfg_    | in  | cfg_we                | cfg_wdata: contraction_mode
//
// An item without tlast is stored and the next one is taken at once.
// An item with tlast starts a contraction: a Lie pass over the element store, then
// each enabled table entry in turn on the one shared multiplier; each disabled
// entry is skipped. s_tready is low for the whole contraction; the result register
// lets items be taken while an earlier result waits for m_tready. Reset clears
// control state and sets the mode to both sums; the element store holds no defined
// reset contents.
module su3_structure_constant_contraction
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // [3:0] element_index, [35:4] element_real,
                                    // [67:36] element_imag, [71:68] zero
    input  logic [1:0]   s_tuser,   // [1:0] matrix_select
    input  logic         s_tlast,   // last_element
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [63:0] result_real, [127:64] result_imag
    output logic         m_tuser,   // [0] saturated
    input  logic         cfg_we,
    input  logic [1:0]   cfg_wdata  // contraction_mode
);
    import su3sc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LIE  = 4'b0010,
        ST_CON  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    state_t       state_reg, state_next;
    logic [1:0]   mode_reg;
    logic [4:0]   comp_reg, comp_next;     // {matrix, component}
    logic [2:0]   sub_reg, sub_next;
    logic [6:0]   ent_reg, ent_next;
    logic [4:0]   step_reg, step_next;
    logic [63:0]  u_reg;
    logic [LW-1:0] lre_reg;
    logic [2*LW-1:0] a_reg, b_reg, c_reg;
    logic [63:0]  pr_reg, pi_reg, qr_reg, qi_reg;
    logic [TW-1:0] tot_r_reg, tot_i_reg;
    logic         sat_reg;
    logic         out_valid_reg;
    logic [127:0] out_data_reg;
    logic         out_sat_reg;

    // element store port
    logic         s_accept;
    logic         st_we;
    logic [4:0]   st_waddr, st_raddr;
    logic [63:0]  st_rdata;

    // Lie store port
    logic         lie_we;
    logic [4:0]   lie_raddr;
    logic [2*LW-1:0] lie_wdata, lie_rdata;

    lie_recipe_t  rec;
    logic [4:0]   mbase;
    logic signed [LW-1:0] ur, ui, vr, vi, lr, li;

    logic [12:0]  w;
    logic         is_f, skip, last_ent, last_comp, out_load, out_ovf_r, out_ovf_i;
    logic [MW-1:0] cpos, cneg, c1, c2;
    logic [63:0]  q1, q2;
    logic signed [MW-1:0] op_a, op_b;
    mac_ctrl_t    mctrl;
    mac_res_t     mres;

    // ---------------------------------------------------------------- stores
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign st_we    = s_accept && (s_tuser != 2'd3) && (s_tdata[3:0] < 4'd9);
    assign st_waddr = {s_tuser, 3'b000} + {3'b000, s_tuser} + {1'b0, s_tdata[3:0]};

    su3sc_ram #(.WIDTH(64), .DEPTH(STORE_DEPTH)) u_store
    (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (s_tdata[67:4]),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    su3sc_ram #(.WIDTH(2 * LW), .DEPTH(LIE_DEPTH)) u_lie
    (
        .clk   (clk),
        .we    (lie_we),
        .waddr (comp_reg),
        .wdata (lie_wdata),
        .raddr (lie_raddr),
        .rdata (lie_rdata)
    );

    su3sc_mac u_mac
    (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .ctrl (mctrl),
        .res  (mres)
    );

    // ------------------------------------------------------------ Lie pass
    always_comb
    begin
        rec      = lie_recipe(comp_reg[2:0]);
        mbase    = {comp_reg[4:3], 3'b000} + {3'b000, comp_reg[4:3]};
        st_raddr = mbase + {1'b0, (sub_reg == 3'd0) ? rec.u : rec.v};
        ur = LW'($signed(u_reg[31:0]));
        ui = LW'($signed(u_reg[63:32]));
        vr = LW'($signed(st_rdata[31:0]));
        vi = LW'($signed(st_rdata[63:32]));
        case (rec.kind)
            LK_ADD:
            begin
                lr = ur + vr;
                li = ui + vi;
            end
            LK_SUB:
            begin
                lr = ur - vr;
                li = ui - vi;
            end
            LK_ISUB:
            begin
                lr = vi - ui;
                li = ur - vr;
            end
            default:
            begin
                lr = lre_reg;
                li = mres.r30[LW-1:0];
            end
        endcase
        lie_wdata = {li, lr};
        last_comp = (comp_reg == 5'(LIE_DEPTH - 1));
    end

    // ------------------------------------------------------- contraction
    always_comb
    begin
        w        = COEF_ROM[ent_reg];
        is_f     = (ent_reg >= 7'(D_ENTRIES));
        skip     = is_f ? (mode_reg == MODE_D) : (mode_reg == MODE_F);
        last_ent = (ent_reg == 7'(N_ENTRIES - 1));
        cpos     = {4'b0000, mag_of(w[11:9])};
        cneg     = -cpos;
        c2       = w[12] ? cneg : cpos;
        c1       = is_f ? -c2 : c2;
        q1       = is_f ? qi_reg : qr_reg;
        q2       = is_f ? qr_reg : qi_reg;
        case (step_reg)
            5'd0:    lie_raddr = {2'b00, w[2:0]};
            5'd1:    lie_raddr = {2'b01, w[5:3]};
            default: lie_raddr = {2'b10, w[8:6]};
        endcase
    end

    // operand selection and accumulator micro-ops
    always_comb
    begin
        op_a  = '0;
        op_b  = '0;
        mctrl = '{op: ACC_HOLD, shift32: 1'b0};
        if (state_reg == ST_LIE)
        begin
            case (sub_reg)
                3'd2:
                begin
                    op_a = -MW'($signed(u_reg[31:0]));
                    op_b = {4'b0000, Q_SQRT3};
                end
                3'd3:
                begin
                    op_a  = -MW'($signed(u_reg[63:32]));
                    op_b  = {4'b0000, Q_SQRT3};
                    mctrl = '{op: ACC_LOAD, shift32: 1'b0};
                end
                3'd4:    mctrl = '{op: ACC_LOAD, shift32: 1'b0};
                default: mctrl = '{op: ACC_HOLD, shift32: 1'b0};
            endcase
        end
        else if (state_reg == ST_CON)
        begin
            case (step_reg)
                5'd3:  begin op_a = {a_reg[LW-1], a_reg[LW-1:0]};
                             op_b = {b_reg[LW-1], b_reg[LW-1:0]}; end
                5'd4:  begin op_a = {a_reg[2*LW-1], a_reg[2*LW-1:LW]};
                             op_b = {b_reg[2*LW-1], b_reg[2*LW-1:LW]};
                             mctrl = '{op: ACC_LOAD, shift32: 1'b0}; end
                5'd5:  begin op_a = {a_reg[LW-1], a_reg[LW-1:0]};
                             op_b = {b_reg[2*LW-1], b_reg[2*LW-1:LW]};
                             mctrl = '{op: ACC_SUB, shift32: 1'b0}; end
                5'd6:  begin op_a = {a_reg[2*LW-1], a_reg[2*LW-1:LW]};
                             op_b = {b_reg[LW-1], b_reg[LW-1:0]};
                             mctrl = '{op: ACC_LOAD, shift32: 1'b0}; end
                5'd7:  begin op_a = {3'b000, pr_reg[31:0]};
                             op_b = {c_reg[LW-1], c_reg[LW-1:0]};
                             mctrl = '{op: ACC_ADD, shift32: 1'b0}; end
                5'd8:  begin op_a = {{3{pr_reg[63]}}, pr_reg[63:32]};
                             op_b = {c_reg[LW-1], c_reg[LW-1:0]};
                             mctrl = '{op: ACC_LOAD, shift32: 1'b0}; end
                5'd9:  begin op_a = {3'b000, pi_reg[31:0]};
                             op_b = {c_reg[2*LW-1], c_reg[2*LW-1:LW]};
                             mctrl = '{op: ACC_ADD, shift32: 1'b1}; end
                5'd10: begin op_a = {{3{pi_reg[63]}}, pi_reg[63:32]};
                             op_b = {c_reg[2*LW-1], c_reg[2*LW-1:LW]};
                             mctrl = '{op: ACC_SUB, shift32: 1'b0}; end
                5'd11: begin op_a = {3'b000, pr_reg[31:0]};
                             op_b = {c_reg[2*LW-1], c_reg[2*LW-1:LW]};
                             mctrl = '{op: ACC_SUB, shift32: 1'b1}; end
                5'd12: begin op_a = {{3{pr_reg[63]}}, pr_reg[63:32]};
                             op_b = {c_reg[2*LW-1], c_reg[2*LW-1:LW]};
                             mctrl = '{op: ACC_LOAD, shift32: 1'b0}; end
                5'd13: begin op_a = {3'b000, pi_reg[31:0]};
                             op_b = {c_reg[LW-1], c_reg[LW-1:0]};
                             mctrl = '{op: ACC_ADD, shift32: 1'b1}; end
                5'd14: begin op_a = {{3{pi_reg[63]}}, pi_reg[63:32]};
                             op_b = {c_reg[LW-1], c_reg[LW-1:0]};
                             mctrl = '{op: ACC_ADD, shift32: 1'b0}; end
                5'd15: mctrl = '{op: ACC_ADD, shift32: 1'b1};
                5'd17: begin op_a = c1; op_b = {3'b000, q1[31:0]}; end
                5'd18: begin op_a = c1; op_b = {{3{q1[63]}}, q1[63:32]};
                             mctrl = '{op: ACC_LOAD, shift32: 1'b0}; end
                5'd19: begin op_a = c2; op_b = {3'b000, q2[31:0]};
                             mctrl = '{op: ACC_ADD, shift32: 1'b1}; end
                5'd20: begin op_a = c2; op_b = {{3{q2[63]}}, q2[63:32]};
                             mctrl = '{op: ACC_LOAD, shift32: 1'b0}; end
                5'd21: mctrl = '{op: ACC_ADD, shift32: 1'b1};
                default: mctrl = '{op: ACC_HOLD, shift32: 1'b0};
            endcase
        end
    end

    // ------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        comp_next  = comp_reg;
        sub_next   = sub_reg;
        ent_next   = ent_reg;
        step_next  = step_reg;
        lie_we     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept && s_tlast)
                begin
                    state_next = ST_LIE;
                    comp_next  = '0;
                    sub_next   = '0;
                end
            end
            ST_LIE:
            begin
                sub_next = sub_reg + 3'd1;
                if ((sub_reg == 3'd5) || (sub_reg == 3'd2 && rec.kind != LK_SQRT))
                begin
                    lie_we    = 1'b1;
                    sub_next  = '0;
                    comp_next = comp_reg + 5'd1;
                    if (last_comp)
                    begin
                        state_next = ST_CON;
                        ent_next   = '0;
                        step_next  = '0;
                    end
                end
            end
            ST_CON:
            begin
                step_next = step_reg + 5'd1;
                if ((step_reg == 5'd0 && skip) || step_reg == 5'd22)
                begin
                    step_next = '0;
                    ent_next  = ent_reg + 7'd1;
                    if (last_ent)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                // hold the total until the result register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_ovf_r = !((&tot_r_reg[TW-1:63]) || !(|tot_r_reg[TW-1:63]));
    assign out_ovf_i = !((&tot_i_reg[TW-1:63]) || !(|tot_i_reg[TW-1:63]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_BOTH;
            comp_reg      <= '0;
            sub_reg       <= '0;
            ent_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            comp_reg  <= comp_next;
            sub_reg   <= sub_next;
            ent_reg   <= ent_next;
            step_reg  <= step_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LIE)
        begin
            if (sub_reg == 3'd1)
            begin
                u_reg <= st_rdata;
            end
            if (sub_reg == 3'd4)
            begin
                lre_reg <= mres.r30[LW-1:0];
            end
        end
        if (state_reg == ST_LIE && last_comp && lie_we)
        begin
            tot_r_reg <= '0;
            tot_i_reg <= '0;
            sat_reg   <= 1'b0;
        end
        if (state_reg == ST_CON)
        begin
            case (step_reg)
                5'd1: a_reg <= lie_rdata;
                5'd2: b_reg <= lie_rdata;
                5'd3: c_reg <= lie_rdata;
                5'd6:
                begin
                    pr_reg  <= mres.r0;
                    sat_reg <= sat_reg | mres.ovf0;
                end
                5'd8:
                begin
                    pi_reg  <= mres.r0;
                    sat_reg <= sat_reg | mres.ovf0;
                end
                5'd12:
                begin
                    qr_reg  <= mres.r16;
                    sat_reg <= sat_reg | mres.ovf16;
                end
                5'd16:
                begin
                    qi_reg  <= mres.r16;
                    sat_reg <= sat_reg | mres.ovf16;
                end
                5'd20:
                begin
                    tot_r_reg <= tot_r_reg + TW'($signed(mres.r30));
                    sat_reg   <= sat_reg | mres.ovf30;
                end
                5'd22:
                begin
                    tot_i_reg <= tot_i_reg + TW'($signed(mres.r30));
                    sat_reg   <= sat_reg | mres.ovf30;
                end
                default: ;
            endcase
        end
        if (out_load)
        begin
            out_data_reg[63:0]   <= out_ovf_r ? (tot_r_reg[TW-1] ? S64_MIN : S64_MAX)
                                              : tot_r_reg[63:0];
            out_data_reg[127:64] <= out_ovf_i ? (tot_i_reg[TW-1] ? S64_MIN : S64_MAX)
                                              : tot_i_reg[63:0];
            out_sat_reg          <= sat_reg | out_ovf_r | out_ovf_i;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;
endmodule

FILE: dv/su3_structure_constant_contraction_test.sv
// Self-checking testbench for su3_structure_constant_contraction: streams matrix elements,
// predicts each contraction bit for bit and compares every result item in order.
// Depends on su3sc_pkg (mode codes) and the RTL of the block.
module su3_structure_constant_contraction_test;
    import su3sc_pkg::*;

    typedef struct {
        logic [1:0]  sel;
        logic [3:0]  idx;
        logic [31:0] re;
        logic [31:0] im;
        logic        last;
    } element_t;

    typedef struct {
        logic [63:0] re;
        logic [63:0] im;
        logic        sat;
    } contraction_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [71:0]  s_tdata;
    logic [1:0]   s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic         m_tuser;
    logic         cfg_we;
    logic [1:0]   cfg_wdata;

    su3_structure_constant_contraction uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow of the block: element store, active mode and the constant table
    logic [63:0]        element_store [27];
    logic [1:0]         mode_shadow;
    logic [12:0]        structure_table [112];
    logic signed [63:0] lie_r [3][8];
    logic signed [63:0] lie_i [3][8];
    bit                 clip;

    element_t     element_queue [$];
    contraction_t pending_results [$];
    bit           failed;
    int           results_seen;

    function automatic logic [12:0] ent(input int p, input int q, input int r,
                                        input int m, input int s);
        return 13'(p | (q << 3) | (r << 6) | (m << 9) | (s << 12));
    endfunction

    function automatic logic signed [63:0] magnitude(input logic [2:0] code);
        case (code)
            3'd0:    return 64'sd1073741824;
            3'd1:    return 64'sd536870912;
            3'd2:    return 64'sd929887697;
            3'd3:    return 64'sd619925131;
            3'd4:    return 64'sd309962566;
            default: return 64'sd0;
        endcase
    endfunction

    function automatic logic signed [127:0] wmul(input logic signed [63:0] x,
                                                 input logic signed [63:0] y);
        logic signed [127:0] a;
        logic signed [127:0] b;
        a = x;
        b = y;
        return a * b;
    endfunction

    // Round half up by sh bits, then clip to 64 bits and note the clip
    function automatic logic signed [63:0] round_clip(input logic signed [127:0] v,
                                                      input int sh);
        logic signed [127:0] t;
        t = v;
        if (sh > 0)
            t = (t + (128'sd1 <<< (sh - 1))) >>> sh;
        if (t > 128'sh7fff_ffff_ffff_ffff)
        begin
            clip = 1'b1;
            return 64'sh7fff_ffff_ffff_ffff;
        end
        if (t < -128'sh8000_0000_0000_0000)
        begin
            clip = 1'b1;
            return 64'sh8000_0000_0000_0000;
        end
        return t[63:0];
    endfunction

    function automatic void lie_components(input int m);
        logic signed [63:0] er [9];
        logic signed [63:0] ei [9];
        for (int k = 0; k < 9; k++)
        begin
            er[k] = $signed(element_store[m * 9 + k][31:0]);
            ei[k] = $signed(element_store[m * 9 + k][63:32]);
        end
        lie_r[m][0] = er[1] + er[3]; lie_i[m][0] = ei[1] + ei[3];
        lie_r[m][1] = ei[3] - ei[1]; lie_i[m][1] = er[1] - er[3];
        lie_r[m][2] = er[0] - er[4]; lie_i[m][2] = ei[0] - ei[4];
        lie_r[m][3] = er[2] + er[6]; lie_i[m][3] = ei[2] + ei[6];
        lie_r[m][4] = ei[6] - ei[2]; lie_i[m][4] = er[2] - er[6];
        lie_r[m][5] = er[5] + er[7]; lie_i[m][5] = ei[5] + ei[7];
        lie_r[m][6] = ei[7] - ei[5]; lie_i[m][6] = er[5] - er[7];
        lie_r[m][7] = round_clip(wmul(-er[8], 64'sd1859775393), 30);
        lie_i[m][7] = round_clip(wmul(-ei[8], 64'sd1859775393), 30);
    endfunction

    // Store the element; on the last one sum the enabled table terms
    function automatic void predict_contraction(input element_t e);
        logic signed [127:0] acc_r;
        logic signed [127:0] acc_i;
        logic signed [63:0]  pr, pi, qr, qi, coef;
        logic [12:0]         w;
        bit                  is_f;
        int                  p, q, r;
        contraction_t        res;
        if (e.sel != 2'd3 && e.idx < 4'd9)
            element_store[e.sel * 9 + e.idx] = {e.im, e.re};
        if (!e.last)
            return;
        for (int m = 0; m < 3; m++)
            lie_components(m);
        clip = 1'b0;
        acc_r = '0;
        acc_i = '0;
        for (int n = 0; n < 112; n++)
        begin
            is_f = n >= 58;
            w = structure_table[n];
            if (is_f ? mode_shadow == MODE_D : mode_shadow == MODE_F)
                continue;
            p = w[2:0];
            q = w[5:3];
            r = w[8:6];
            coef = magnitude(w[11:9]);
            if (w[12])
                coef = -coef;
            pr = round_clip(wmul(lie_r[0][p], lie_r[1][q]) - wmul(lie_i[0][p], lie_i[1][q]), 0);
            pi = round_clip(wmul(lie_r[0][p], lie_i[1][q]) + wmul(lie_i[0][p], lie_r[1][q]), 0);
            qr = round_clip(wmul(pr, lie_r[2][r]) - wmul(pi, lie_i[2][r]), 16);
            qi = round_clip(wmul(pr, lie_i[2][r]) + wmul(pi, lie_r[2][r]), 16);
            if (is_f)
            begin
                acc_r += round_clip(wmul(-coef, qi), 30);
                acc_i += round_clip(wmul(coef, qr), 30);
            end
            else
            begin
                acc_r += round_clip(wmul(coef, qr), 30);
                acc_i += round_clip(wmul(coef, qi), 30);
            end
        end
        res.re = round_clip(acc_r, 0);
        res.im = round_clip(acc_i, 0);
        res.sat = clip;
        pending_results.push_back(res);
    endfunction

    function automatic logic [31:0] pick_part();
        case ($urandom_range(0, 15))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return $urandom();
            4:       return 32'hffff_ffff;
            default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
        endcase
    endfunction

    function automatic int pick_gap();
        int g;
        g = $urandom_range(0, 99);
        if (g < 50)
            return 0;
        if (g < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic void queue_element(input int sel, input int idx, input logic [31:0] re,
                                          input logic [31:0] im, input bit last);
        element_t e;
        e.sel = 2'(sel);
        e.idx = 4'(idx);
        e.re = re;
        e.im = im;
        e.last = last;
        element_queue.push_back(e);
    endfunction

    // Random item: mostly valid addresses, sometimes a bad one, tlast now and then
    function automatic void queue_random_element();
        int sel;
        int idx;
        sel = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
        idx = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
        queue_element(sel, idx, pick_part(), pick_part(), $urandom_range(0, 17) == 0);
    endfunction

    initial
    begin
        structure_table = '{
            ent(0,0,7,3,0), ent(0,3,5,1,0), ent(0,4,6,1,0), ent(0,5,3,1,0), ent(0,6,4,1,0),
            ent(0,7,0,3,0), ent(1,1,7,3,0), ent(1,3,6,1,1), ent(1,4,5,1,0), ent(1,5,4,1,0),
            ent(1,6,3,1,1), ent(1,7,1,3,0), ent(2,2,7,3,0), ent(2,3,3,1,0), ent(2,4,4,1,0),
            ent(2,5,5,1,1), ent(2,6,6,1,1), ent(2,7,2,3,0), ent(3,0,5,1,0), ent(3,1,6,1,1),
            ent(3,2,3,1,0), ent(3,3,2,1,0), ent(3,3,7,4,1), ent(3,5,0,1,0), ent(3,6,1,1,1),
            ent(3,7,3,4,1), ent(4,0,6,1,0), ent(4,1,5,1,0), ent(4,2,4,1,0), ent(4,4,2,1,0),
            ent(4,4,7,4,1), ent(4,5,1,1,0), ent(4,6,0,1,0), ent(4,7,4,4,1), ent(5,0,3,1,0),
            ent(5,1,4,1,0), ent(5,2,5,1,1), ent(5,3,0,1,0), ent(5,4,1,1,0), ent(5,5,2,1,1),
            ent(5,5,7,4,1), ent(5,7,5,4,1), ent(6,0,4,1,0), ent(6,1,3,1,1), ent(6,2,6,1,1),
            ent(6,3,1,1,1), ent(6,4,0,1,0), ent(6,6,2,1,1), ent(6,6,7,4,1), ent(6,7,6,4,1),
            ent(7,0,0,3,0), ent(7,1,1,3,0), ent(7,2,2,3,0), ent(7,3,3,4,1), ent(7,4,4,4,1),
            ent(7,5,5,4,1), ent(7,6,6,4,1), ent(7,7,7,3,1),
            ent(0,1,2,0,0), ent(0,2,1,0,1), ent(0,3,6,1,0), ent(0,4,5,1,1), ent(0,5,4,1,0),
            ent(0,6,3,1,1), ent(1,0,2,0,1), ent(1,2,0,0,0), ent(1,3,5,1,0), ent(1,4,6,1,0),
            ent(1,5,3,1,1), ent(1,6,4,1,1), ent(2,0,1,0,0), ent(2,1,0,0,1), ent(2,3,4,1,0),
            ent(2,4,3,1,1), ent(2,5,6,1,1), ent(2,6,5,1,0), ent(3,0,6,1,1), ent(3,1,5,1,1),
            ent(3,2,4,1,1), ent(3,4,2,1,0), ent(3,4,7,2,0), ent(3,5,1,1,0), ent(3,6,0,1,0),
            ent(3,7,4,2,1), ent(4,0,5,1,0), ent(4,1,6,1,1), ent(4,2,3,1,0), ent(4,3,2,1,1),
            ent(4,3,7,2,1), ent(4,5,0,1,1), ent(4,6,1,1,0), ent(4,7,3,2,0), ent(5,0,4,1,1),
            ent(5,1,3,1,0), ent(5,2,6,1,0), ent(5,3,1,1,1), ent(5,4,0,1,0), ent(5,6,2,1,1),
            ent(5,6,7,2,0), ent(5,7,6,2,1), ent(6,0,3,1,0), ent(6,1,4,1,0), ent(6,2,5,1,1),
            ent(6,3,0,1,1), ent(6,4,1,1,1), ent(6,5,2,1,0), ent(6,5,7,2,1), ent(6,7,5,2,0),
            ent(7,3,4,2,0), ent(7,4,3,2,1), ent(7,5,6,2,0), ent(7,6,5,2,1)
        };
        foreach (element_store[k])
            element_store[k] = '0;
    end

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Driver: take the next element from the queue once the current one is accepted,
    // with a random gap between items; predict on acceptance.
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                element_t got;
                got.sel = s_tuser;
                got.idx = s_tdata[3:0];
                got.re = s_tdata[35:4];
                got.im = s_tdata[67:36];
                got.last = s_tlast;
                predict_contraction(got);
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (element_queue.size() > 0)
                begin
                    element_t nxt;
                    nxt = element_queue.pop_front();
                    s_tdata <= {4'd0, nxt.im, nxt.re, nxt.idx};
                    s_tuser <= nxt.sel;
                    s_tlast <= nxt.last;
                    s_tvalid <= 1'b1;
                    send_gap = pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random stalls on m_tready, plus one long hold-off that backs the block up
    int  stall_left;
    bit  long_hold_done;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
            long_hold_done = 1'b0;
            results_seen = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                contraction_t exp_res;
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with none expected: re=%h im=%h sat=%b", $time,
                             m_tdata[63:0], m_tdata[127:64], m_tuser);
                    failed = 1'b1;
                end
                else
                begin
                    exp_res = pending_results.pop_front();
                    if (m_tdata[63:0] !== exp_res.re)
                    begin
                        $display("%0t: result_real expected %h actual %h", $time,
                                 exp_res.re, m_tdata[63:0]);
                        failed = 1'b1;
                    end
                    if (m_tdata[127:64] !== exp_res.im)
                    begin
                        $display("%0t: result_imag expected %h actual %h", $time,
                                 exp_res.im, m_tdata[127:64]);
                        failed = 1'b1;
                    end
                    if (m_tuser !== exp_res.sat)
                    begin
                        $display("%0t: saturated expected %b actual %b", $time,
                                 exp_res.sat, m_tuser);
                        failed = 1'b1;
                    end
                end
            end
            if (!long_hold_done && results_seen == 8)
            begin
                // hold off long enough for two contractions to back up
                long_hold_done = 1'b1;
                stall_left = 7000;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                stall_left = pick_gap();
                m_tready <= (stall_left == 0);
            end
        end
    end

    // Write the mode only while idle; the shadow follows at the same edge
    task automatic write_mode(input logic [1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        mode_shadow = value;
    endtask

    // Hold the sender until everything sent has come back, then let the block settle
    task automatic drain();
        while (element_queue.size() > 0 || s_tvalid || pending_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    logic [1:0] phase_modes [6];
    initial
    begin
        phase_modes = '{MODE_D, MODE_F, MODE_BOTH, 2'd3, MODE_D, MODE_BOTH};
        failed = 1'b0;
        mode_shadow = MODE_BOTH;
        rst_n = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: fill every entry with extremes, contract in the reset mode,
        // then bad addresses with tlast, then rewrites of two entries.
        for (int k = 0; k < 27; k++)
        begin
            logic [31:0] vals [6];
            vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h1, 32'h0001_0000};
            queue_element(k / 9, k % 9, vals[k % 6], vals[(k + 2) % 6], k == 26);
        end
        queue_element(3, 2, 32'h1234_5678, 32'h8765_4321, 1'b1);
        queue_element(1, 15, 32'hdead_beef, 32'h0bad_f00d, 1'b1);
        queue_element(2, 8, 32'h0002_0000, 32'hfffe_0000, 1'b0);
        queue_element(0, 8, 32'h0000_8000, 32'h0001_8000, 1'b1);
        drain();

        // Random phases, each under its own mode; the extremes 0 and 3 are among them
        foreach (phase_modes[n])
        begin
            write_mode(phase_modes[n]);
            repeat (320) queue_random_element();
            queue_random_element();
            element_queue[$].last = 1'b1;
            drain();
        end

        repeat (100) @(posedge clk);
        if (!failed)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #100000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
